// ===== hw/rtl/vtb_pkg.sv =====
// Shared types and constants for the virtual timer bank.
// No dependencies; used by every module under hw/rtl.
`timescale 1ns / 1ps
`default_nettype none

package vtb_pkg;

   localparam int unsigned CNT_W   = 16;
   localparam int unsigned PHASE_W = 4;
   localparam int unsigned SEL_W   = 2;
   localparam int unsigned CMD_W   = 2;

   // Phase steps 0..9 and wraps
   localparam logic [PHASE_W-1:0] PHASE_LAST = 4'd9;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK   = 2'd0,
      CMD_START  = 2'd1,
      CMD_STOP   = 2'd2,
      CMD_STATUS = 2'd3
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // One entry of the timer store
   typedef struct packed {
      logic             one_shot;
      logic [CNT_W-1:0] reload;
      logic [CNT_W-1:0] count;
   } timer_word_type;

   // Access request from the sequencer to the timer store
   typedef struct packed {
      logic               rd_en;
      logic [PHASE_W-1:0] rd_addr;
      logic               wr_en;
      logic [PHASE_W-1:0] wr_addr;
      timer_word_type     wr_data;
   } ram_req_type;

endpackage

`default_nettype wire

// ===== hw/rtl/virtual_timer_bank_top.sv =====
// Top level of the virtual timer bank: sequencer plus timer store.
// Depends on vtb_pkg, vtb_seq and vtb_timer_ram.
`timescale 1ns / 1ps
`default_nettype none

// A request accepted while idle reads its entry into the store's read register;
//   the execute state then registers its result on the rsp_ ports, marked by rsp_valid.
// A new request is taken only while idle; busy is high for the cycle in which
//   the timer store read returns and the entry is modified and written back.
// Reset (synchronous, active high) clears the phase, all running bits and all
//   expiry flags; the store holds count, reload and mode only once a timer starts.
module virtual_timer_bank_top #(
   parameter int unsigned NUM_TIMERS = 4
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   output logic                       busy,
   input  wire  [vtb_pkg::CMD_W-1:0]  req_command,
   input  wire  [vtb_pkg::SEL_W-1:0]  req_timer_select,
   input  wire  [vtb_pkg::CNT_W-1:0]  req_reload_value,
   input  wire                        req_one_shot,
   output logic                       rsp_valid,
   output logic                       rsp_fired,
   output logic [vtb_pkg::SEL_W-1:0]  rsp_fired_timer,
   output logic                       rsp_running_status,
   output logic [vtb_pkg::CNT_W-1:0]  rsp_count_status,
   output logic                       rsp_flag_status
);

   // Store access from the sequencer, and the registered read data back
   vtb_pkg::ram_req_type    ram_req;
   vtb_pkg::timer_word_type ram_rd_data;

   // Sequence each request: advance the phase on a tick, read the entry,
   // then modify and write it back where the command changes it, while the result registers load
   vtb_seq #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_timer_select   (req_timer_select),
      .req_reload_value   (req_reload_value),
      .req_one_shot       (req_one_shot),
      .rsp_valid          (rsp_valid),
      .rsp_fired          (rsp_fired),
      .rsp_fired_timer    (rsp_fired_timer),
      .rsp_running_status (rsp_running_status),
      .rsp_count_status   (rsp_count_status),
      .rsp_flag_status    (rsp_flag_status),
      .ram_req            (ram_req),
      .ram_rd_data        (ram_rd_data)
   );

   // Hold count, reload and mode of every timer
   vtb_timer_ram #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_timer_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/vtb_timer_ram.sv =====
// Timer store: count, reload and mode of each timer in one synchronous memory.
// Depends on vtb_pkg for the entry and request types.
`timescale 1ns / 1ps
`default_nettype none

module vtb_timer_ram #(
   parameter int unsigned NUM_TIMERS = 4
) (
   input  wire                     clock,
   input  vtb_pkg::ram_req_type    ram_req,
   output vtb_pkg::timer_word_type rd_data
);

   localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   vtb_pkg::timer_word_type mem [NUM_TIMERS];
   vtb_pkg::timer_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr[IDX_W-1:0]] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr[IDX_W-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/vtb_seq.sv =====
// Request sequencer: phase counter, running and flag bits, read-modify-write
// of the timer store and the result register. Depends on vtb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vtb_seq #(
   parameter int unsigned NUM_TIMERS = 4
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire  [vtb_pkg::CMD_W-1:0]           req_command,
   input  wire  [vtb_pkg::SEL_W-1:0]           req_timer_select,
   input  wire  [vtb_pkg::CNT_W-1:0]           req_reload_value,
   input  wire                                 req_one_shot,
   output logic                                rsp_valid,
   output logic                                rsp_fired,
   output logic [vtb_pkg::SEL_W-1:0]           rsp_fired_timer,
   output logic                                rsp_running_status,
   output logic [vtb_pkg::CNT_W-1:0]           rsp_count_status,
   output logic                                rsp_flag_status,
   output vtb_pkg::ram_req_type                ram_req,
   input  vtb_pkg::timer_word_type             ram_rd_data
);

   localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam logic [vtb_pkg::PHASE_W-1:0] NUM_T = vtb_pkg::PHASE_W'(NUM_TIMERS);

   vtb_pkg::state_type             state_ff, state_in;
   logic [vtb_pkg::PHASE_W-1:0]    phase_ff, phase_in;
   logic [NUM_TIMERS-1:0]          running_ff, running_in;
   logic [NUM_TIMERS-1:0]          flag_ff, flag_in;

   vtb_pkg::cmd_type               cmd_ff;
   logic [vtb_pkg::PHASE_W-1:0]    tgt_ff;
   logic                           hit_ff;
   logic [vtb_pkg::CNT_W-1:0]      rel_ff;
   logic                           os_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_fired_ff, rsp_fired_in;
   logic [vtb_pkg::SEL_W-1:0]      rsp_fired_timer_ff, rsp_fired_timer_in;
   logic                           rsp_running_ff, rsp_running_in;
   logic [vtb_pkg::CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                           rsp_flag_ff, rsp_flag_in;

   vtb_pkg::cmd_type               req_cmd;
   logic                           accept;
   logic [vtb_pkg::PHASE_W-1:0]    phase_adv;
   logic [vtb_pkg::PHASE_W-1:0]    tgt_new;
   logic                           hit_new;
   logic [IDX_W-1:0]               idx;
   logic [vtb_pkg::CNT_W-1:0]      base_cnt;
   logic [vtb_pkg::CNT_W-1:0]      dec_cnt;
   logic                           expire;

   assign req_cmd   = vtb_pkg::cmd_type'(req_command);
   assign accept    = start && (state_ff == vtb_pkg::ST_IDLE);
   assign busy      = (state_ff == vtb_pkg::ST_EXEC);
   assign phase_adv = (phase_ff == vtb_pkg::PHASE_LAST) ? '0 : phase_ff + 1'b1;
   assign tgt_new   = (req_cmd == vtb_pkg::CMD_TICK) ? phase_adv
                      : {{(vtb_pkg::PHASE_W - vtb_pkg::SEL_W){1'b0}}, req_timer_select};
   assign hit_new   = (tgt_new < NUM_T);

   assign idx       = tgt_ff[IDX_W-1:0];
   // A zero count takes the reload value before the decrement
   assign base_cnt  = (ram_rd_data.count == '0) ? ram_rd_data.reload : ram_rd_data.count;
   assign dec_cnt   = base_cnt - 1'b1;
   assign expire    = (dec_cnt == '0);

   always_comb begin
      state_in           = state_ff;
      phase_in           = phase_ff;
      running_in         = running_ff;
      flag_in            = flag_ff;
      rsp_valid_in       = 1'b0;
      rsp_fired_in       = 1'b0;
      rsp_fired_timer_in = '0;
      rsp_running_in     = 1'b0;
      rsp_count_in       = '0;
      rsp_flag_in        = 1'b0;
      ram_req            = '0;
      ram_req.rd_addr    = tgt_new;
      ram_req.wr_addr    = tgt_ff;
      ram_req.wr_data    = ram_rd_data;

      unique case (state_ff)
         vtb_pkg::ST_IDLE: begin
            if (accept) begin
               state_in      = vtb_pkg::ST_EXEC;
               ram_req.rd_en = hit_new;
               if (req_cmd == vtb_pkg::CMD_TICK) begin
                  phase_in = phase_adv;
               end
            end
         end
         vtb_pkg::ST_EXEC: begin
            state_in     = vtb_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
            unique case (cmd_ff)
               vtb_pkg::CMD_TICK: begin
                  if (hit_ff && running_ff[idx]) begin
                     ram_req.wr_en         = 1'b1;
                     ram_req.wr_data.count = dec_cnt;
                     if (expire) begin
                        flag_in[idx]       = 1'b1;
                        rsp_fired_in       = 1'b1;
                        rsp_fired_timer_in = tgt_ff[vtb_pkg::SEL_W-1:0];
                        if (ram_rd_data.one_shot) begin
                           running_in[idx] = 1'b0;
                        end else begin
                           ram_req.wr_data.count = ram_rd_data.reload;
                        end
                     end
                  end
               end
               vtb_pkg::CMD_START: begin
                  if (hit_ff) begin
                     ram_req.wr_en            = 1'b1;
                     ram_req.wr_data.one_shot = os_ff;
                     ram_req.wr_data.reload   = rel_ff;
                     ram_req.wr_data.count    = rel_ff;
                     running_in[idx]          = 1'b1;
                     flag_in[idx]             = 1'b0;
                  end
               end
               vtb_pkg::CMD_STOP: begin
                  if (hit_ff) begin
                     running_in[idx] = 1'b0;
                  end
               end
               vtb_pkg::CMD_STATUS: begin
                  if (hit_ff) begin
                     rsp_running_in = running_ff[idx];
                     rsp_count_in   = ram_rd_data.count;
                     rsp_flag_in    = flag_ff[idx];
                     flag_in[idx]   = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = vtb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vtb_pkg::ST_IDLE;
         phase_ff     <= '0;
         running_ff   <= '0;
         flag_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         running_ff   <= running_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request payload and result fields
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
         tgt_ff <= tgt_new;
         hit_ff <= hit_new;
         rel_ff <= req_reload_value;
         os_ff  <= req_one_shot;
      end
      rsp_fired_ff       <= rsp_fired_in;
      rsp_fired_timer_ff <= rsp_fired_timer_in;
      rsp_running_ff     <= rsp_running_in;
      rsp_count_ff       <= rsp_count_in;
      rsp_flag_ff        <= rsp_flag_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_fired          = rsp_fired_ff;
   assign rsp_fired_timer    = rsp_fired_timer_ff;
   assign rsp_running_status = rsp_running_ff;
   assign rsp_count_status   = rsp_count_ff;
   assign rsp_flag_status    = rsp_flag_ff;

`ifndef SYNTH
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == vtb_pkg::ST_EXEC))
      else $error("response strobe without an executed request");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == vtb_pkg::ST_EXEC))
      else $error("accepted request did not enter execution");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= vtb_pkg::PHASE_LAST)
      else $error("phase counter out of range");

   a_fired_no_status: assert property (@(posedge clock) disable iff (reset)
      rsp_fired_ff |-> (!rsp_flag_ff && !rsp_running_ff && (rsp_count_ff == '0)))
      else $error("fired result carries status fields");
`endif

endmodule

`default_nettype wire
